/* src/sida_pkg.sv */
// ----------------------------------------------------------------------------
// sida_pkg: shared types and constants for the integer to ASCII converter
// Holds the controller state type, the BCD cell constants and ASCII codes.
// ----------------------------------------------------------------------------
package sida_pkg;

    localparam int DIGIT_W = 4;

    // Double-dabble correction: a digit of five or more gets three added
    // before the shift so that it carries cleanly into the next decade.
    localparam logic [DIGIT_W-1:0] BCD_ADJ_MIN = 4'd5;
    localparam logic [DIGIT_W-1:0] BCD_ADJ_ADD = 4'd3;

    localparam logic [6:0] CHAR_MINUS = 7'd45;
    localparam logic [6:0] CHAR_ZERO  = 7'd48;
    localparam logic [6:0] CHAR_NINE  = 7'd57;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV,
        ST_FIN,
        ST_SIGN,
        ST_EMIT
    } sida_state_t;

endpackage

/* src/sida_bcd_cell.sv */
// ----------------------------------------------------------------------------
// sida_bcd_cell: one decimal digit of the shift-and-add-3 converter
// Holds one BCD digit, corrects it and shifts one bit in from the lower cell.
// ----------------------------------------------------------------------------
module sida_bcd_cell
    import sida_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               clr,
    input  logic               shift,
    input  logic               shin,
    output logic               shout,
    output logic [DIGIT_W-1:0] digit
);

    logic [DIGIT_W-1:0] digit_reg;
    logic [DIGIT_W-1:0] digit_next;
    logic [DIGIT_W-1:0] digit_adj;

    assign digit_adj = (digit_reg >= BCD_ADJ_MIN) ? (digit_reg + BCD_ADJ_ADD) : digit_reg;
    assign shout     = digit_adj[DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (clr)
        begin
            digit_next = '0;
        end
        else if (shift)
        begin
            digit_next = {digit_adj[DIGIT_W-2:0], shin};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_reg <= '0;
        end
        else
        begin
            digit_reg <= digit_next;
        end
    end

endmodule

/* src/signed_int_to_decimal_ascii.sv */
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts a two's complement integer to its decimal characters, MSD first.
// ----------------------------------------------------------------------------
// One integer enters on the s_ group while the block is idle. The magnitude
// is shifted, one bit per cycle, into a row of BCD digit cells (shift and
// add three), after the load in the idle state; a final state then settles
// the digit count. The characters then leave on the m_ group at up to one
// per cycle as m_tready allows: a '-' first for a negative value, then the
// digits without leading zeros, m_tlast set on the final digit. Zero gives
// a single '0'; the most negative value prints exactly. At VALUE_BITS = 32
// an integer gives one to eleven characters. The next integer is taken
// only once the last character of the current one is gone.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_BITS = 32
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // value (VALUE_BITS, signed), zero padded to whole bytes
    input  logic [((VALUE_BITS+7)/8)*8-1:0]      s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // character [6:0], zero pad [7]
    output logic [7:0]                           m_tdata,
    output logic                                 m_tlast
);

    // Decimal digits needed for a VALUE_BITS magnitude (log10(2) ~ 0.301).
    localparam int NDIG = (VALUE_BITS * 301) / 1000 + 1;
    localparam int IW   = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int CW   = $clog2(NDIG + 1);
    localparam int BW   = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    sida_state_t state_reg, state_next;

    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic                  sign_reg, sign_next;
    logic [BW-1:0]         bit_cnt_reg, bit_cnt_next;
    logic [CW-1:0]         ndig_reg, ndig_next;
    logic [IW-1:0]         ptr_reg, ptr_next;

    logic [VALUE_BITS-1:0] value_in;
    logic                  in_fire;
    logic                  out_fire;
    logic                  cell_clr;
    logic                  cell_shift;
    logic [IW-1:0]         rd_idx;
    logic [DIGIT_W-1:0]    rd_digit;
    logic [6:0]            out_char;

    logic [NDIG-1:0][DIGIT_W-1:0] digits;
    logic [NDIG:0]                carry;

    assign value_in = s_tdata[VALUE_BITS-1:0];
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    // ------------------------------------------------------------------
    // Row of BCD cells: the magnitude MSB enters cell 0, carries ripple up
    // ------------------------------------------------------------------
    assign carry[0] = mag_reg[VALUE_BITS-1];

    genvar gi;
    generate
        for (gi = 0; gi < NDIG; gi++)
        begin : g_cell
            sida_bcd_cell u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .clr   (cell_clr),
                .shift (cell_shift),
                .shin  (carry[gi]),
                .shout (carry[gi+1]),
                .digit (digits[gi])
            );
        end
    endgenerate

    // One read port on the digit row: the count probe while converting,
    // the emit pointer while sending.
    assign rd_idx   = (state_reg == ST_EMIT) ? ptr_reg : ndig_reg[IW-1:0];
    assign rd_digit = digits[rd_idx];
    assign out_char = CHAR_ZERO + {3'b000, rd_digit};

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        sign_next    = sign_reg;
        bit_cnt_next = bit_cnt_reg;
        ndig_next    = ndig_reg;
        ptr_next     = ptr_reg;
        cell_clr     = 1'b0;
        cell_shift   = 1'b0;
        s_tready     = 1'b0;
        m_tvalid     = 1'b0;
        m_tdata      = 8'h00;
        m_tlast      = 1'b0;

        // Digit count grows by at most one per shift: advance it when the
        // next cell up has become nonzero.
        if ((state_reg == ST_CONV) || (state_reg == ST_FIN))
        begin
            if ((ndig_reg < CW'(NDIG)) && (rd_digit != '0))
            begin
                ndig_next = ndig_reg + CW'(1);
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    sign_next    = value_in[VALUE_BITS-1];
                    mag_next     = value_in[VALUE_BITS-1] ? (~value_in + 1'b1) : value_in;
                    bit_cnt_next = BW'(VALUE_BITS - 1);
                    ndig_next    = CW'(1);
                    cell_clr     = 1'b1;
                    state_next   = ST_CONV;
                end
            end

            ST_CONV:
            begin
                cell_shift = 1'b1;
                mag_next   = {mag_reg[VALUE_BITS-2:0], 1'b0};
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - BW'(1);
                end
            end

            ST_FIN:
            begin
                // Last count probe happens here; start at the top digit.
                ptr_next   = IW'(ndig_next - CW'(1));
                state_next = sign_reg ? ST_SIGN : ST_EMIT;
            end

            ST_SIGN:
            begin
                m_tvalid = 1'b1;
                m_tdata  = {1'b0, CHAR_MINUS};
                if (m_tready)
                begin
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                m_tvalid = 1'b1;
                m_tdata  = {1'b0, out_char};
                m_tlast  = (ptr_reg == '0);
                if (m_tready)
                begin
                    if (ptr_reg == '0)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        ptr_next = ptr_reg - IW'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            bit_cnt_reg <= '0;
            ndig_reg    <= '0;
            ptr_reg     <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            bit_cnt_reg <= bit_cnt_next;
            ndig_reg    <= ndig_next;
            ptr_reg     <= ptr_next;
        end
    end

    // Payload: no reset needed
    always_ff @(posedge clk)
    begin
        mag_reg  <= mag_next;
        sign_reg <= sign_next;
    end

`ifndef SYNTH
    // Never take a new integer while characters are still being sent.
    a_no_accept_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input accepted while output pending");

    // An accepted integer starts conversion; nothing leaves the next cycle.
    a_accept_starts_conv: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (!m_tvalid && !s_tready))
        else $error("output or accept right after input transaction");

    // The final character of a number returns the block to idle.
    a_last_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && m_tlast) |=> s_tready)
        else $error("block not idle after last character");

    // Only '-' or a decimal digit ever leaves, and '-' is never last.
    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[6:0] == CHAR_MINUS && !m_tlast) ||
                      (m_tdata[6:0] >= CHAR_ZERO && m_tdata[6:0] <= CHAR_NINE)))
        else $error("bad output character");
`endif

endmodule
